// ----- src/ssd_pkg.sv -----
package ssd_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int VALUE_W    = 14;
  localparam int CODE_W     = 5;
  localparam int BYTE_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int CODE_PORTS = 4;

  localparam int DIGIT_COUNT_DEF = 4;
  localparam int MAX_VALUE       = 2 ** VALUE_W - 1;

  // A 14-bit value has at most five decimal digits
  localparam int QUOT_COUNT = 5;

  // Reciprocals for v / 10^k, k = 1..4: ceil(2^28 / 10^k), exact for all 14-bit v
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 25;
  localparam logic [QUOT_COUNT-2:0][RECIP_W-1:0] RECIP_MULT = {
    25'd26844, 25'd268436, 25'd2684355, 25'd26843546
  };

  // Two codes plus number: the number saturates at two digits
  localparam logic [VALUE_W-1:0] MIX_LIMIT = 14'd99;

  // Glyph table, active-low segments a..g then h from the MSB down
  localparam int GLYPH_COUNT = 20;
  localparam logic [BYTE_W-1:0] BLANK_SEGMENTS = 8'hFF;
  localparam logic [GLYPH_COUNT-1:0][BYTE_W-1:0] SEG_TABLE = {
    8'h11, 8'h91, 8'hD1, 8'h85, 8'hC1, 8'h61, 8'hE1, 8'h63, 8'h31, 8'hFD,
    8'h09, 8'h01, 8'h1F, 8'h41, 8'h49, 8'h99, 8'h0D, 8'h25, 8'h9F, 8'h03
  };

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_NUM   = 2'd0,
    CMD_LOAD_MIX   = 2'd1,
    CMD_LOAD_CODES = 2'd2,
    CMD_SCAN       = 2'd3
  } ssd_cmd_t;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [VALUE_W-1:0] value_t;

  // Item as it leaves the quotient stage
  typedef struct packed {
    logic                                 valid;
    ssd_cmd_t                             cmd;
    logic [QUOT_COUNT-1:0][VALUE_W-1:0]   quot;
    logic [CODE_PORTS-1:0][CODE_W-1:0]    code;
  } ssd_stage_t;

  function automatic logic [BYTE_W-1:0] seg_lookup(code_t c);
    if (c < CODE_W'(GLYPH_COUNT)) begin
      return SEG_TABLE[c];
    end
    return BLANK_SEGMENTS;
  endfunction

  // Elaboration-time power of ten
  function automatic int pow10(int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

endpackage

// ----- src/ssd_in_if.sv -----
interface ssd_in_if import ssd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] value;
  logic [CODE_W-1:0]  pos0_code;
  logic [CODE_W-1:0]  pos1_code;
  logic [CODE_W-1:0]  pos2_code;
  logic [CODE_W-1:0]  pos3_code;

  modport source (
    output valid, command, value, pos0_code, pos1_code, pos2_code, pos3_code,
    input  ready
  );
  modport sink (
    input  valid, command, value, pos0_code, pos1_code, pos2_code, pos3_code,
    output ready
  );
endinterface

// ----- src/ssd_out_if.sv -----
interface ssd_out_if import ssd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] digit_select;
  logic [BYTE_W-1:0] segments;

  modport source (
    output valid, digit_select, segments,
    input  ready
  );
  modport sink (
    input  valid, digit_select, segments,
    output ready
  );
endinterface

// ----- src/seven_segment_scan_driver.sv -----
// Multiplexed seven-segment scan driver.
// in_ch takes one item per command: load a decimal number (split into digits,
// saturating at the display width), load two glyph codes plus a two-digit
// number (saturating at 99), load four glyph codes, or a scan tick.
// out_ch gives one item per scan tick: a one-hot digit select for the current
// position and the active-low segment byte of its glyph; loads give nothing.
// An item passes an input register, a quotient register (reciprocal multiplies
// for the digit split) and the glyph store/result register, where a scan
// result is registered. One item is accepted every cycle while in_ch.ready is
// high; the rate is set by the single multiply level between registers.
// Items stay in order, so a scan always sees every load accepted before it.
// When out_ch stalls the result register holds; loads behind it keep flowing
// until a scan tick reaches the last stage, then the two earlier registers
// fill and in_ch.ready falls.
// Synchronous reset clears the glyph store to code 0 on every position, sets
// the scan position to 0 and empties all stages.
module seven_segment_scan_driver import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ssd_in_if.sink    in_ch,
  ssd_out_if.source out_ch
);

  ssd_stage_t stage;
  logic       stage_ready;

  // Saturation and quotients
  ssd_split #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_split (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .stage_o       (stage),
    .stage_ready_i (stage_ready)
  );

  // Glyph store, scan and result register
  ssd_glyph #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_glyph (
    .clk           (clk),
    .rst_n         (rst_n),
    .stage_i       (stage),
    .stage_ready_o (stage_ready),
    .out_ch        (out_ch)
  );

endmodule

// ----- src/ssd_split.sv -----
module ssd_split import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ssd_in_if.sink     in_ch,
  output ssd_stage_t stage_o,
  input  logic       stage_ready_i
);

  localparam int Pow10 = pow10(DIGIT_COUNT);
  localparam logic [VALUE_W-1:0] SatLimit =
    (Pow10 - 1 > MAX_VALUE) ? VALUE_W'(MAX_VALUE) : VALUE_W'(Pow10 - 1);
  localparam int ProdW = VALUE_W + RECIP_SHIFT;

  // Input register
  logic                              s1_valid_r;
  ssd_cmd_t                          s1_cmd_r;
  value_t                            s1_value_r;
  logic [CODE_PORTS-1:0][CODE_W-1:0] s1_code_r;

  // Quotient register
  logic                               stage_valid_r;
  ssd_cmd_t                           stage_cmd_r;
  logic [QUOT_COUNT-1:0][VALUE_W-1:0] stage_quot_r;
  logic [CODE_PORTS-1:0][CODE_W-1:0]  stage_code_r;

  logic   s2_free;
  logic   s1_free;
  value_t limit;
  value_t v_sat;
  logic [QUOT_COUNT-1:0][VALUE_W-1:0] quot;

  // Stage flow: each register refills when its successor takes its item
  assign s2_free     = !stage_valid_r || stage_ready_i;
  assign s1_free     = !s1_valid_r || s2_free;
  assign in_ch.ready = s1_free;

  // Saturate, two digits for the mixed load
  always_comb begin
    limit = (s1_cmd_r == CMD_LOAD_MIX) ? MIX_LIMIT : SatLimit;
    v_sat = (s1_value_r > limit) ? limit : s1_value_r;
  end

  // v / 10^k by reciprocal multiply, all k in parallel
  assign quot[0] = v_sat;
  for (genvar k = 1; k < QUOT_COUNT; k++) begin : g_quot
    logic [ProdW-1:0] prod;
    assign prod    = ProdW'(v_sat) * ProdW'(RECIP_MULT[k-1]);
    assign quot[k] = prod[RECIP_SHIFT +: VALUE_W];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      stage_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_free) begin
        stage_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s1_free && in_ch.valid) begin
      s1_cmd_r     <= ssd_cmd_t'(in_ch.command);
      s1_value_r   <= in_ch.value;
      s1_code_r[0] <= in_ch.pos0_code;
      s1_code_r[1] <= in_ch.pos1_code;
      s1_code_r[2] <= in_ch.pos2_code;
      s1_code_r[3] <= in_ch.pos3_code;
    end
    if (s2_free && s1_valid_r) begin
      stage_cmd_r  <= s1_cmd_r;
      stage_quot_r <= quot;
      stage_code_r <= s1_code_r;
    end
  end

  assign stage_o.valid = stage_valid_r;
  assign stage_o.cmd   = stage_cmd_r;
  assign stage_o.quot  = stage_quot_r;
  assign stage_o.code  = stage_code_r;

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && !stage_ready_i |=>
      stage_valid_r && $stable(stage_cmd_r) && $stable(stage_quot_r))
    else $error("quotient stage lost its item under stall");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_free |=> s1_valid_r && $stable(s1_value_r) && $stable(s1_cmd_r))
    else $error("input register lost its item under stall");

endmodule

// ----- src/ssd_glyph.sv -----
module ssd_glyph import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ssd_stage_t stage_i,
  output logic       stage_ready_o,
  ssd_out_if.source  out_ch
);

  localparam int PosW     = $clog2(DIGIT_COUNT);
  localparam int ExtCount = (DIGIT_COUNT > QUOT_COUNT) ? DIGIT_COUNT : QUOT_COUNT;

  code_t             store_r [DIGIT_COUNT];
  logic [PosW-1:0]   pos_r;
  logic [PosW-1:0]   pos_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_sel_r;
  logic [BYTE_W-1:0] out_seg_r;

  logic out_free;
  logic is_scan;
  logic load_fire;
  logic scan_fire;
  logic [ExtCount-1:0][DIGIT_W-1:0] digit_ext;

  assign out_free      = !out_valid_r || out_ch.ready;
  assign is_scan       = (stage_i.cmd == CMD_SCAN);
  assign stage_ready_o = !is_scan || out_free;
  assign load_fire     = stage_i.valid && !is_scan;
  assign scan_fire     = stage_i.valid && is_scan && out_free;

  // Digit k = q_k - 10 * q_(k+1); positions past five digits hold zero
  for (genvar k = 0; k < ExtCount; k++) begin : g_digit
    if (k < QUOT_COUNT - 1) begin : g_mid
      logic [VALUE_W-1:0] diff;
      assign diff = stage_i.quot[k]
                  - ((stage_i.quot[k+1] << 3) + (stage_i.quot[k+1] << 1));
      assign digit_ext[k] = diff[DIGIT_W-1:0];
    end else if (k == QUOT_COUNT - 1) begin : g_top
      assign digit_ext[k] = stage_i.quot[k][DIGIT_W-1:0];
    end else begin : g_zero
      assign digit_ext[k] = '0;
    end
  end

  // Glyph store, one entry per position
  for (genvar p = 0; p < DIGIT_COUNT; p++) begin : g_pos
    code_t mix_val;
    code_t codes_val;
    code_t glyph_nxt;

    // Mixed load: codes on positions 0 and 1, units then tens on 2 and 3
    if (p < 2) begin : g_mix_code
      assign mix_val = stage_i.code[p];
    end else if (p < 4) begin : g_mix_digit
      assign mix_val = CODE_W'(digit_ext[p-2]);
    end else begin : g_mix_keep
      assign mix_val = store_r[p];
    end

    if (p < CODE_PORTS) begin : g_codes
      assign codes_val = stage_i.code[p];
    end else begin : g_codes_keep
      assign codes_val = store_r[p];
    end

    always_comb begin
      glyph_nxt = store_r[p];
      if (load_fire) begin
        unique case (stage_i.cmd)
          CMD_LOAD_NUM:   glyph_nxt = CODE_W'(digit_ext[p]);
          CMD_LOAD_MIX:   glyph_nxt = mix_val;
          CMD_LOAD_CODES: glyph_nxt = codes_val;
          default:        glyph_nxt = store_r[p];
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        store_r[p] <= '0;
      end else begin
        store_r[p] <= glyph_nxt;
      end
    end
  end

  // Scan position wraps after the last digit
  assign pos_nxt = (pos_r == PosW'(DIGIT_COUNT - 1)) ? '0 : pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (scan_fire) begin
        pos_r <= pos_nxt;
      end
      out_valid_r <= scan_fire || (out_valid_r && !out_ch.ready);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (scan_fire) begin
      out_sel_r <= BYTE_W'(1) << pos_r;
      out_seg_r <= seg_lookup(store_r[pos_r]);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.digit_select = out_sel_r;
  assign out_ch.segments     = out_seg_r;

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(out_sel_r))
    else $error("digit select not one-hot");

  a_scan_select: assert property (@(posedge clk) disable iff (!rst_n)
    scan_fire |=> out_valid_r && out_sel_r == (BYTE_W'(1) << $past(pos_r)))
    else $error("scan item did not select its position");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire && !out_free |=> out_valid_r && $stable(out_seg_r) && $stable(out_sel_r))
    else $error("load item disturbed a waiting result");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosW'(DIGIT_COUNT - 1))
    else $error("scan position out of range");

endmodule

// ----- tb/sv/tb_seven_segment_scan_driver.sv -----
module tb_seven_segment_scan_driver;
  import ssd_pkg::*;

  localparam int POSITIONS    = 4;
  localparam int NUMBER_CAP   = 9999;
  localparam int PAIR_CAP     = 99;
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_START   = 200;
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  // Active-low segment patterns, one per defined glyph code
  localparam int GLYPHS = 20;
  localparam logic [7:0] GLYPH_SEGS [0:GLYPHS-1] = '{
    8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09,
    8'hFD, 8'h31, 8'h63, 8'hE1, 8'h61, 8'hC1, 8'h85, 8'hD1, 8'h91, 8'h11
  };

  typedef struct packed {
    logic [7:0] digit_select;
    logic [7:0] segments;
  } scan_result_t;

  // Mirror of the glyph store and scan position; queues the scan results due
  class display_mirror;
    code_t        glyphs [POSITIONS];
    logic [1:0]   scan_pos;
    scan_result_t due_scans [$];
    int           errors;

    function new();
      foreach (glyphs[i]) glyphs[i] = '0;
      scan_pos = '0;
      errors   = 0;
    endfunction

    function logic [7:0] segments_of(code_t c);
      if (c < GLYPHS) return GLYPH_SEGS[c];
      return 8'hFF;
    endfunction

    function int pending();
      return due_scans.size();
    endfunction

    // Apply one accepted item to the mirror
    function void note_command(ssd_cmd_t cmd, value_t value,
                               code_t c0, code_t c1, code_t c2, code_t c3);
      int           v;
      scan_result_t r;
      v = value;
      case (cmd)
        CMD_LOAD_NUM: begin
          if (v > NUMBER_CAP) v = NUMBER_CAP;
          for (int i = 0; i < POSITIONS; i++) begin
            glyphs[i] = code_t'(v % 10);
            v = v / 10;
          end
        end
        CMD_LOAD_MIX: begin
          if (v > PAIR_CAP) v = PAIR_CAP;
          glyphs[0] = c0;
          glyphs[1] = c1;
          glyphs[2] = code_t'(v % 10);
          glyphs[3] = code_t'(v / 10);
        end
        CMD_LOAD_CODES: begin
          glyphs[0] = c0;
          glyphs[1] = c1;
          glyphs[2] = c2;
          glyphs[3] = c3;
        end
        default: begin
          r.digit_select = 8'b1 << scan_pos;
          r.segments     = segments_of(glyphs[scan_pos]);
          due_scans.push_back(r);
          scan_pos = scan_pos + 2'd1;
        end
      endcase
    endfunction

    // Compare one result item with the oldest scan due
    function void check_scan(logic [7:0] digit_select, logic [7:0] segments);
      scan_result_t want;
      if (due_scans.size() == 0) begin
        $error("unexpected result: digit_select %02h segments %02h",
               digit_select, segments);
        errors++;
        return;
      end
      want = due_scans.pop_front();
      if (digit_select !== want.digit_select) begin
        $error("digit_select: expected %02h, actual %02h", want.digit_select, digit_select);
        errors++;
      end
      if (segments !== want.segments) begin
        $error("segments: expected %02h, actual %02h", want.segments, segments);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ssd_in_if  in_ch ();
  ssd_out_if out_ch ();

  display_mirror mirror;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            recv_cycle;
  int            cycle_count;

  seven_segment_scan_driver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_cycle   <= 0;
    end else begin
      recv_cycle <= recv_cycle + 1;
      if (recv_cycle >= HOLD_START && recv_cycle < HOLD_START + HOLD_LEN) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitors on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        mirror.check_scan(out_ch.digit_select, out_ch.segments);
      end
      if (in_ch.valid && in_ch.ready) begin
        mirror.note_command(ssd_cmd_t'(in_ch.command), in_ch.value, in_ch.pos0_code,
                            in_ch.pos1_code, in_ch.pos2_code, in_ch.pos3_code);
      end
    end
  end

  // Offer one item, with random idle cycles ahead of it; returns once accepted
  task automatic offer(ssd_cmd_t cmd, value_t value,
                       code_t c0, code_t c1, code_t c2, code_t c3);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.value     <= value;
    in_ch.pos0_code <= c0;
    in_ch.pos1_code <= c1;
    in_ch.pos2_code <= c2;
    in_ch.pos3_code <= c3;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic code_t pick_code();
    if ($urandom_range(99) < 80) return code_t'($urandom_range(0, GLYPHS - 1));
    return code_t'($urandom_range(0, 31));
  endfunction

  // Random item: scans dominate so results keep flowing
  task automatic offer_random();
    int       pick;
    int       r;
    ssd_cmd_t cmd;
    value_t   value;
    pick = $urandom_range(99);
    r    = $urandom_range(99);
    if (pick < 45) cmd = CMD_SCAN;
    else if (pick < 65) cmd = CMD_LOAD_NUM;
    else if (pick < 80) cmd = CMD_LOAD_MIX;
    else cmd = CMD_LOAD_CODES;
    case (cmd)
      CMD_LOAD_NUM: value = (r < 85) ? value_t'($urandom_range(0, NUMBER_CAP))
                                     : value_t'($urandom_range(NUMBER_CAP + 1, MAX_VALUE));
      CMD_LOAD_MIX: begin
        if (r < 70) value = value_t'($urandom_range(0, PAIR_CAP));
        else if (r < 90) value = value_t'($urandom_range(PAIR_CAP + 1, 200));
        else value = value_t'($urandom_range(0, MAX_VALUE));
      end
      default: value = value_t'($urandom_range(0, MAX_VALUE));
    endcase
    offer(cmd, value, pick_code(), pick_code(), pick_code(), pick_code());
  endtask

  initial begin
    mirror          = new();
    cycle_count     = 0;
    send_idle_pct   = 28;
    recv_idle_pct   = 80;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_SCAN;
    in_ch.value     = '0;
    in_ch.pos0_code = '0;
    in_ch.pos1_code = '0;
    in_ch.pos2_code = '0;
    in_ch.pos3_code = '0;
    out_ch.ready    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset contents, saturation, blank codes, wrap of the scan
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_LOAD_NUM,   14'd16383, 5'd31, 5'd31, 5'd31, 5'd31);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_SCAN,       14'd16383, 5'd31, 5'd31, 5'd31, 5'd31);
    offer(CMD_LOAD_NUM,   14'd10000, 5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_LOAD_NUM,   14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_LOAD_CODES, 14'd16383, 5'd19, 5'd20, 5'd31, 5'd0);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_LOAD_MIX,   14'd99,    5'd10, 5'd18, 5'd0,  5'd0);
    offer(CMD_LOAD_MIX,   14'd100,   5'd31, 5'd21, 5'd0,  5'd0);
    offer(CMD_LOAD_MIX,   14'd16383, 5'd11, 5'd12, 5'd31, 5'd31);
    offer(CMD_LOAD_MIX,   14'd0,     5'd13, 5'd14, 5'd0,  5'd0);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_LOAD_CODES, 14'd0,     5'd15, 5'd16, 5'd17, 5'd9);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);
    offer(CMD_SCAN,       14'd0,     5'd0,  5'd0,  5'd0,  5'd0);

    // Random phases: slow receiver, then slow sender, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct <= 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct <= 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      repeat (RANDOM_ITEMS / 3) offer_random();
      // Sender pauses until the display has caught up
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (mirror.pending() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
